>>> rtl/core/fqs_pkg.sv
`timescale 1ns / 1ps
// types and constants shared by the queue with statistics
package fqs_pkg;

    localparam int VALUE_W = 32;
    localparam int TIME_W  = 32;
    localparam int SUM_W   = 36;
    localparam int COUNT_W = 5;

    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH_CMP,
        ST_POP_LD
    } t_state;

    typedef struct packed {
        t_mode                      mode;
        logic signed [VALUE_W-1:0]  entry_value;
        logic signed [TIME_W-1:0]   entry_time;
    } t_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  front_value;
        logic signed [TIME_W-1:0]   front_time;
        logic                       is_empty;
        logic [COUNT_W-1:0]         entry_count;
        logic signed [SUM_W-1:0]    value_sum;
        logic signed [VALUE_W-1:0]  largest_value;
        logic                       overflow;
    } t_res;

endpackage

>>> rtl/core/fqs_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram with registered read
module fqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/fifo_queue_with_stats.sv
`timescale 1ns / 1ps
// bounded fifo queue of value/time entries with count, sum and maximum
//
// A request is taken at a rising edge with start high and busy low. Its
// i_req.mode selects a push of entry_value/entry_time at the rear or a pop
// of the front entry. Exactly one result per request appears on o_res for
// one cycle with o_strobe high; the receiver cannot stall it.
// Entries live in a ring ram; the running maximum is kept in a second ram
// holding a non-increasing candidate deque of (value, position) pairs.
// Path of a request, from acceptance to the strobe:
//   pop of a non-empty queue: via ST_POP_LD (ram read of the new front)
//   pop of an empty queue, push into a full queue: answered from ST_IDLE
//   push: in ST_PUSH_CMP until no smaller candidate is at the deque back
//   (each entry is dropped from the deque at most once)
// Set by the registered ram read and the deque back-scan loop.
// The strobe comes in the cycle busy falls, so a new request may be taken
// while a result is shown. Reset empties the queue at once; ram contents
// are not cleared since only held entries are ever read.
module fifo_queue_with_stats #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  fqs_pkg::t_req i_req,
    output logic          o_strobe,
    output fqs_pkg::t_res o_res
);

    localparam int AW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int VW   = fqs_pkg::VALUE_W;
    localparam int TW   = fqs_pkg::TIME_W;
    localparam int SW   = fqs_pkg::SUM_W;
    localparam int EW   = VW + TW;
    localparam int DW   = AW + VW;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] x);
        return (x == AW'(QUEUE_DEPTH - 1)) ? '0 : AW'(x + AW'(1));
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] x);
        return (x == '0) ? AW'(QUEUE_DEPTH - 1) : AW'(x - AW'(1));
    endfunction

    fqs_pkg::t_state r_state, n_state;
    logic [AW-1:0]        r_rd_idx, n_rd_idx;
    logic [AW-1:0]        r_wr_idx, n_wr_idx;
    logic [CW-1:0]        r_fill, n_fill;
    logic signed [SW-1:0] r_sum, n_sum;
    logic signed [VW-1:0] r_front_val, n_front_val;
    logic signed [TW-1:0] r_front_time, n_front_time;
    logic [AW-1:0]        r_dq_head, n_dq_head;
    logic [AW-1:0]        r_dq_tail, n_dq_tail;
    logic [CW-1:0]        r_dq_cnt, n_dq_cnt;
    logic signed [VW-1:0] r_dq_val, n_dq_val;
    logic [AW-1:0]        r_dq_pos, n_dq_pos;
    logic                 r_dq_pop, n_dq_pop;
    logic signed [VW-1:0] r_val, n_val;
    logic [AW-1:0]        r_push_pos, n_push_pos;
    logic                 r_strobe;
    fqs_pkg::t_res        r_res, n_res;
    logic                 w_finish;
    logic                 w_ovf;

    logic                 w_ent_we;
    logic [AW-1:0]        w_ent_waddr;
    logic [EW-1:0]        w_ent_wdata;
    logic [AW-1:0]        w_ent_raddr;
    logic [EW-1:0]        w_ent_rdata;
    logic                 w_dq_we;
    logic [AW-1:0]        w_dq_waddr;
    logic [DW-1:0]        w_dq_wdata;
    logic [AW-1:0]        w_dq_raddr;
    logic [DW-1:0]        w_dq_rdata;
    logic signed [VW-1:0] w_dq_rval;
    logic [fqs_pkg::COUNT_W+CW-1:0] w_cnt_ext;

    fqs_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_waddr (w_ent_waddr),
        .i_wdata (w_ent_wdata),
        .i_raddr (w_ent_raddr),
        .o_rdata (w_ent_rdata)
    );

    fqs_ram #(.WIDTH(DW), .DEPTH(QUEUE_DEPTH)) u_deque_ram (
        .i_clk   (i_clk),
        .i_we    (w_dq_we),
        .i_waddr (w_dq_waddr),
        .i_wdata (w_dq_wdata),
        .i_raddr (w_dq_raddr),
        .o_rdata (w_dq_rdata)
    );

    assign w_dq_rval = w_dq_rdata[VW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fqs_pkg::ST_IDLE;
            r_rd_idx  <= '0;
            r_wr_idx  <= '0;
            r_fill    <= '0;
            r_sum     <= '0;
            r_dq_head <= '0;
            r_dq_tail <= '0;
            r_dq_cnt  <= '0;
            r_dq_pop  <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_idx  <= n_rd_idx;
            r_wr_idx  <= n_wr_idx;
            r_fill    <= n_fill;
            r_sum     <= n_sum;
            r_dq_head <= n_dq_head;
            r_dq_tail <= n_dq_tail;
            r_dq_cnt  <= n_dq_cnt;
            r_dq_pop  <= n_dq_pop;
            r_strobe  <= w_finish;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front_val  <= n_front_val;
        r_front_time <= n_front_time;
        r_dq_val     <= n_dq_val;
        r_dq_pos     <= n_dq_pos;
        r_val        <= n_val;
        r_push_pos   <= n_push_pos;
        if (w_finish) begin
            r_res <= n_res;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_rd_idx     = r_rd_idx;
        n_wr_idx     = r_wr_idx;
        n_fill       = r_fill;
        n_sum        = r_sum;
        n_front_val  = r_front_val;
        n_front_time = r_front_time;
        n_dq_head    = r_dq_head;
        n_dq_tail    = r_dq_tail;
        n_dq_cnt     = r_dq_cnt;
        n_dq_val     = r_dq_val;
        n_dq_pos     = r_dq_pos;
        n_dq_pop     = r_dq_pop;
        n_val        = r_val;
        n_push_pos   = r_push_pos;
        w_finish     = 1'b0;
        w_ovf        = 1'b0;
        w_ent_we     = 1'b0;
        w_ent_waddr  = r_wr_idx;
        w_ent_wdata  = {i_req.entry_time, i_req.entry_value};
        w_ent_raddr  = f_inc(r_rd_idx);
        w_dq_we      = 1'b0;
        w_dq_waddr   = r_dq_tail;
        w_dq_wdata   = {r_push_pos, r_val};
        w_dq_raddr   = f_dec(r_dq_tail);

        unique case (r_state)
            fqs_pkg::ST_IDLE: begin
                if (start) begin
                    if (i_req.mode == fqs_pkg::MODE_PUSH) begin
                        if (r_fill >= CW'(QUEUE_DEPTH)) begin
                            w_ovf    = 1'b1;
                            w_finish = 1'b1;
                        end else begin
                            w_ent_we   = 1'b1;
                            n_wr_idx   = f_inc(r_wr_idx);
                            n_fill     = CW'(r_fill + CW'(1));
                            n_sum      = r_sum + {{(SW - VW){i_req.entry_value[VW-1]}},
                                                  i_req.entry_value};
                            n_val      = i_req.entry_value;
                            n_push_pos = r_wr_idx;
                            if (r_fill == '0) begin
                                n_front_val  = i_req.entry_value;
                                n_front_time = i_req.entry_time;
                            end
                            n_state = fqs_pkg::ST_PUSH_CMP;
                        end
                    end else if (r_fill != '0) begin
                        n_sum    = r_sum - {{(SW - VW){r_front_val[VW-1]}}, r_front_val};
                        n_rd_idx = f_inc(r_rd_idx);
                        n_fill   = CW'(r_fill - CW'(1));
                        n_dq_pop = (r_dq_cnt != '0) && (r_dq_pos == r_rd_idx);
                        if (n_dq_pop) begin
                            n_dq_head = f_inc(r_dq_head);
                            n_dq_cnt  = CW'(r_dq_cnt - CW'(1));
                        end
                        w_dq_raddr = f_inc(r_dq_head);
                        n_state    = fqs_pkg::ST_POP_LD;
                    end else begin
                        w_finish = 1'b1;
                    end
                end
            end
            fqs_pkg::ST_PUSH_CMP: begin
                // drop smaller candidates from the deque back
                if ((r_dq_cnt != '0) && (w_dq_rval < r_val)) begin
                    n_dq_tail  = f_dec(r_dq_tail);
                    n_dq_cnt   = CW'(r_dq_cnt - CW'(1));
                    w_dq_raddr = f_dec(f_dec(r_dq_tail));
                end else begin
                    w_dq_we   = 1'b1;
                    n_dq_tail = f_inc(r_dq_tail);
                    n_dq_cnt  = CW'(r_dq_cnt + CW'(1));
                    if (r_dq_cnt == '0) begin
                        n_dq_val = r_val;
                        n_dq_pos = r_push_pos;
                    end
                    w_finish = 1'b1;
                    n_state  = fqs_pkg::ST_IDLE;
                end
            end
            fqs_pkg::ST_POP_LD: begin
                n_front_val  = w_ent_rdata[VW-1:0];
                n_front_time = w_ent_rdata[EW-1:VW];
                if (r_dq_pop) begin
                    n_dq_val = w_dq_rval;
                    n_dq_pos = w_dq_rdata[DW-1:VW];
                end
                w_finish = 1'b1;
                n_state  = fqs_pkg::ST_IDLE;
            end
            default: begin
                n_state = fqs_pkg::ST_IDLE;
            end
        endcase
    end

    assign w_cnt_ext = {{fqs_pkg::COUNT_W{1'b0}}, n_fill};

    always_comb begin
        n_res.front_value   = (n_fill != '0) ? n_front_val : '0;
        n_res.front_time    = (n_fill != '0) ? n_front_time : '0;
        n_res.is_empty      = (n_fill == '0);
        n_res.entry_count   = w_cnt_ext[fqs_pkg::COUNT_W-1:0];
        n_res.value_sum     = n_sum;
        n_res.largest_value = (n_fill != '0) ? n_dq_val : '0;
        n_res.overflow      = w_ovf;
    end

    assign busy     = (r_state != fqs_pkg::ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> r_state == fqs_pkg::ST_IDLE)
        else $error("result strobe while a request is still in work");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || r_strobe))
        else $error("accepted request neither in work nor answered");

    a_deque_matches_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fqs_pkg::ST_IDLE) |-> ((r_fill == '0) == (r_dq_cnt == '0)))
        else $error("candidate deque empty state disagrees with fill count");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= CW'(QUEUE_DEPTH)) && (r_dq_cnt <= r_fill || busy))
        else $error("fill or deque count out of range");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_res.overflow) |-> r_fill == CW'(QUEUE_DEPTH))
        else $error("overflow flagged on a queue that is not full");

endmodule
